// ===== hdl/tlba_pkg.sv =====
// shared types and constants for the two-level bitmap block allocator
package tlba_pkg;
    localparam int IDX_W  = 14;
    localparam int CNT_W  = 15;
    localparam int CFG_W  = 7;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_MARK    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2,
        ST_SAME    = 2'd3
    } t_status;

    localparam logic [1:0] REG_GROUPS_IN_USE = 2'd0;
endpackage

// ===== hdl/tlba_if.sv =====
// valid/ready channel interfaces for requests and results
interface tlba_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   operation;
    logic [tlba_pkg::IDX_W-1:0]   block_index;
    modport source (output valid, output operation, output block_index, input ready);
    modport sink   (input valid, input operation, input block_index, output ready);
endinterface

interface tlba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tlba_pkg::IDX_W-1:0]   result_block;
    logic [1:0]                   status;
    logic [tlba_pkg::CNT_W-1:0]   free_count;
    modport source (output valid, output result_block, output status, output free_count,
                    input ready);
    modport sink   (input valid, input result_block, input status, input free_count,
                    output ready);
endinterface

// ===== hdl/tlba_map_ram.sv =====
// free map memory, one word per entry, registered read
module tlba_map_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== hdl/two_level_bitmap_block_allocator.sv =====
// top level: two-level bitmap block allocator with apb config port
// After reset a clearing pass writes zero to every map word, GROUP_COUNT *
// GROUP_BLOCKS / WORD_BITS words (256 with defaults), while no request is
// taken. A request then takes one transaction at a time: mark and release
// read one map word, then mark scans the group's words to decide fullness;
// allocate finds the first group with a clear full flag (lowest index wins,
// among groups in use), then walks that group's words until a free bit, then
// scans the group's words again to decide fullness. Every map access steps
// through an issue, a wait and a check state. Range errors and the idle
// operation go straight to the result without a map access.
// The result then sits in the output register until taken, and the next
// request is accepted only after the result has left.
module two_level_bitmap_block_allocator #(
    parameter int GROUP_COUNT  = 64,
    parameter int GROUP_BLOCKS = 256,
    parameter int WORD_BITS    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlba_req_if.sink    i_req,
    tlba_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tlba_pkg::*;

    localparam int DEPTH  = GROUP_COUNT * GROUP_BLOCKS / WORD_BITS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GW     = GROUP_BLOCKS / WORD_BITS;        // words per group
    localparam int GWW    = (GW > 1) ? $clog2(GW) : 1;
    localparam int GIW    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int BW     = $clog2(WORD_BITS);
    localparam int OFFW   = $clog2(GROUP_BLOCKS);
    localparam int ABW    = GIW + OFFW;                       // absolute block bits
    localparam int CAPW   = ABW + 2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FIND, S_AREAD, S_AWAIT, S_ACHK,
        S_MREAD, S_MWAIT, S_MCHK, S_FREAD, S_FWAIT, S_FCHK, S_DONE
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_groups;
    logic [GROUP_COUNT-1:0] r_full;
    logic [CNT_W-1:0]     r_used;
    logic [AW-1:0]        r_clr;
    logic [1:0]           r_op;
    logic [IDX_W-1:0]     r_idx;
    logic [GIW-1:0]       r_grp;
    logic [GWW-1:0]       r_wsel;
    logic [AW-1:0]        r_waddr;
    logic [BW-1:0]        r_bit;
    logic [IDX_W-1:0]     r_res;
    logic [1:0]           r_stat;
    logic                 r_ovalid;
    logic [CNT_W-1:0]     r_ofree;

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [WORD_BITS-1:0] wdata, rdata;

    tlba_map_ram #(.DEPTH(DEPTH), .WIDTH(WORD_BITS)) u_map (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // effective groups and capacity
    logic [GIW:0]  eff;
    logic [CAPW-1:0] cap;
    always_comb begin
        if (32'(r_groups) > GROUP_COUNT) begin
            eff = (GIW+1)'(GROUP_COUNT);
        end else begin
            eff = (GIW+1)'(r_groups);
        end
        cap = CAPW'(eff) * CAPW'(GROUP_BLOCKS);
    end

    // first group below eff with clear full flag
    logic             fnd;
    logic [GIW-1:0]   fgrp;
    always_comb begin
        fnd  = 1'b0;
        fgrp = '0;
        for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
            if (!r_full[g] && ((GIW+1)'(g) < eff)) begin
                fnd  = 1'b1;
                fgrp = GIW'(g);
            end
        end
    end

    // lowest zero bit of the read word
    logic           zfnd;
    logic [BW-1:0]  zbit;
    always_comb begin
        zfnd = 1'b0;
        zbit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!rdata[b]) begin
                zfnd = 1'b1;
                zbit = BW'(b);
            end
        end
    end

    logic [AW-1:0] idx_word, grp_base;
    assign idx_word = AW'(r_idx >> BW);
    assign grp_base = AW'(32'(r_grp) * GW);

    logic [CAPW-1:0] free_calc;
    always_comb begin
        if (cap > CAPW'(r_used)) begin
            free_calc = cap - CAPW'(r_used);
        end else begin
            free_calc = '0;
        end
    end

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GROUPS_IN_USE[0]) ? 32'(r_groups) : '0;

    // map port control
    always_comb begin
        we    = 1'b0;
        waddr = r_waddr;
        wdata = rdata;
        raddr = r_waddr;
        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
            end
            S_ACHK: begin
                we    = zfnd;
                wdata = rdata | (WORD_BITS'(1) << zbit);
            end
            S_MCHK: begin
                we = (rdata[r_bit] != (r_op == OP_MARK));
                if (r_op == OP_MARK) begin
                    wdata = rdata | (WORD_BITS'(1) << r_bit);
                end else begin
                    wdata = rdata & ~(WORD_BITS'(1) << r_bit);
                end
            end
            // hold the scan address through the read latency
            S_FREAD, S_FWAIT: raddr = grp_base + AW'(r_wsel);
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.result_block = r_res;
    assign o_rsp.status = r_stat;
    assign o_rsp.free_count = r_ofree;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_groups <= CFG_W'(64);
            r_full   <= '0;
            r_used   <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_wr && paddr[2] == REG_GROUPS_IN_USE[0]) begin
                r_groups <= pwdata[CFG_W-1:0];
            end
            if (o_rsp.valid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (32'(r_clr) == DEPTH - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_op  <= i_req.operation;
                        r_idx <= i_req.block_index;
                        if (i_req.operation == OP_ALLOC) begin
                            r_res   <= i_req.block_index;
                            r_stat  <= ST_OK;
                            r_state <= S_FIND;
                        end else if (i_req.operation == OP_NONE) begin
                            r_res   <= '0;
                            r_stat  <= ST_OK;
                            r_state <= S_DONE;
                        end else if (CAPW'(i_req.block_index) >= cap) begin
                            r_res   <= i_req.block_index;
                            r_stat  <= ST_RANGE;
                            r_state <= S_DONE;
                        end else begin
                            r_res   <= i_req.block_index;
                            r_stat  <= ST_OK;
                            r_state <= S_MREAD;
                        end
                    end
                end
                S_FIND: begin
                    if (fnd) begin
                        r_grp   <= fgrp;
                        r_wsel  <= '0;
                        r_waddr <= AW'(32'(fgrp) * GW);
                        r_state <= S_AREAD;
                    end else begin
                        r_res   <= '0;
                        r_stat  <= ST_NO_FREE;
                        r_state <= S_DONE;
                    end
                end
                S_AREAD: r_state <= S_AWAIT;
                S_AWAIT: r_state <= S_ACHK;
                S_ACHK: begin
                    if (zfnd) begin
                        r_used  <= r_used + CNT_W'(1);
                        r_res   <= IDX_W'((32'(r_waddr) << BW) + 32'(zbit));
                        r_wsel  <= '0;
                        r_state <= S_FREAD;
                    end else if (32'(r_wsel) == GW - 1) begin
                        r_res   <= '0;
                        r_stat  <= ST_NO_FREE;
                        r_state <= S_DONE;
                    end else begin
                        r_wsel  <= r_wsel + GWW'(1);
                        r_waddr <= r_waddr + AW'(1);
                        r_state <= S_AREAD;
                    end
                end
                S_MREAD: begin
                    r_waddr <= idx_word;
                    r_bit   <= BW'(r_idx);
                    r_grp   <= GIW'(r_idx >> OFFW);
                    r_state <= S_MWAIT;
                end
                S_MWAIT: r_state <= S_MCHK;
                S_MCHK: begin
                    if (rdata[r_bit] == (r_op == OP_MARK)) begin
                        r_stat  <= ST_SAME;
                        r_state <= S_DONE;
                    end else if (r_op == OP_MARK) begin
                        r_used  <= r_used + CNT_W'(1);
                        r_wsel  <= '0;
                        r_state <= S_FREAD;
                    end else begin
                        if (r_used != '0) begin
                            r_used <= r_used - CNT_W'(1);
                        end
                        r_full[r_grp] <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                // fullness scan, read issued with write already landed
                S_FREAD: r_state <= S_FWAIT;
                S_FWAIT: r_state <= S_FCHK;
                S_FCHK: begin
                    if (rdata != '1) begin
                        r_state <= S_DONE;
                    end else if (32'(r_wsel) == GW - 1) begin
                        r_full[r_grp] <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_wsel  <= r_wsel + GWW'(1);
                        r_state <= S_FREAD;
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_ofree  <= (free_calc > CAPW'(32767)) ? CNT_W'(32767)
                                                           : CNT_W'(free_calc);
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // no request taken during the clearing pass
    a_no_req_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_req.ready)
        else $error("request taken during clear");
    // a no-free result always reports block zero
    a_nofree_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_NO_FREE) |-> (o_rsp.result_block == '0))
        else $error("no-free result with nonzero block");
    // a map write on allocate always comes with a used-count increment
    a_alloc_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACHK && we) |=> (r_used == $past(r_used) + CNT_W'(1)))
        else $error("allocate write without count update");
endmodule

// ===== bench/tb_two_level_bitmap_block_allocator.sv =====
// testbench for the two-level bitmap block allocator: directed table plus random traffic
module tb_two_level_bitmap_block_allocator;
    import tlba_pkg::*;

    localparam int GROUPS     = 64;
    localparam int GRP_BLOCKS = 256;
    localparam int TOTAL      = GROUPS * GRP_BLOCKS;
    localparam int FREE_SAT   = 32767;
    localparam int N_RANDOM   = 565;

    typedef struct packed {
        logic [IDX_W-1:0] blk;
        t_status          status;
        logic [CNT_W-1:0] free_cnt;
    } t_result;

    // directed row: request plus optional typed-in expectation
    typedef struct {
        t_op              op;
        logic [IDX_W-1:0] idx;
        bit               has_exp;
        t_result          exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tlba_req_if req_if ();
    tlba_rsp_if rsp_if ();

    two_level_bitmap_block_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: block map, full flags, used count, group setting
    bit              blk_used [TOTAL];
    bit              grp_full [GROUPS];
    int unsigned     used_blocks;
    int unsigned     grp_setting;

    t_result         pending_results[$];
    int unsigned     mismatches;

    function automatic bit group_all_used(int unsigned g);
        for (int unsigned b = 0; b < GRP_BLOCKS; b++) begin
            if (!blk_used[g*GRP_BLOCKS + b]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // apply one request to the predictor, return the expected transaction
    function automatic t_result allocate_predict(t_op op, logic [IDX_W-1:0] idx);
        int unsigned eff;
        int unsigned cap;
        int unsigned fc;
        bit          found;
        t_result     r;
        eff = (grp_setting > GROUPS) ? GROUPS : grp_setting;
        cap = eff * GRP_BLOCKS;
        r.blk = '0;
        r.status = ST_OK;
        found = 1'b0;
        case (op)
            OP_ALLOC: begin
                for (int unsigned g = 0; g < eff && !found; g++) begin
                    if (grp_full[g]) continue;
                    for (int unsigned b = 0; b < GRP_BLOCKS; b++) begin
                        if (!blk_used[g*GRP_BLOCKS + b]) begin
                            blk_used[g*GRP_BLOCKS + b] = 1'b1;
                            used_blocks++;
                            if (group_all_used(g)) grp_full[g] = 1'b1;
                            r.blk = IDX_W'(g*GRP_BLOCKS + b);
                            found = 1'b1;
                            break;
                        end
                    end
                    // an unflagged group with no free block ends the search
                    if (!found) break;
                end
                if (!found) begin
                    r.blk = '0;
                    r.status = ST_NO_FREE;
                end
            end
            OP_MARK, OP_RELEASE: begin
                r.blk = idx;
                if (idx >= cap) begin
                    r.status = ST_RANGE;
                end else if (blk_used[idx] == (op == OP_MARK)) begin
                    r.status = ST_SAME;
                end else if (op == OP_MARK) begin
                    blk_used[idx] = 1'b1;
                    used_blocks++;
                    if (group_all_used(idx / GRP_BLOCKS)) grp_full[idx / GRP_BLOCKS] = 1'b1;
                end else begin
                    blk_used[idx] = 1'b0;
                    if (used_blocks > 0) used_blocks--;
                    grp_full[idx / GRP_BLOCKS] = 1'b0;
                end
            end
            default: ;
        endcase
        fc = (cap > used_blocks) ? cap - used_blocks : 0;
        if (fc > FREE_SAT) fc = FREE_SAT;
        r.free_cnt = CNT_W'(fc);
        return r;
    endfunction

    // receiver: stalls on its own rotating pattern, checks each transaction
    logic [15:0] stall_pattern = 16'b1011_0001_1110_0100;
    int unsigned rsp_cycle;
    initial begin
        rsp_if.ready = 1'b0;
        rsp_cycle = 0;
    end

    always @(posedge i_clk) begin
        if (rsp_if.valid && rsp_if.ready) begin
            t_result got;
            t_result want;
            got.blk      = rsp_if.result_block;
            got.status   = t_status'(rsp_if.status);
            got.free_cnt = rsp_if.free_count;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected transaction: expected none, actual blk=%0d st=%0d free=%0d",
                         $time, got.blk, got.status, got.free_cnt);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.blk !== want.blk) begin
                    $display("%0t result_block: expected %0d, actual %0d",
                             $time, want.blk, got.blk);
                    mismatches++;
                end
                if (got.status !== want.status) begin
                    $display("%0t status: expected %0d, actual %0d",
                             $time, want.status, got.status);
                    mismatches++;
                end
                if (got.free_cnt !== want.free_cnt) begin
                    $display("%0t free_count: expected %0d, actual %0d",
                             $time, want.free_cnt, got.free_cnt);
                    mismatches++;
                end
            end
        end
        rsp_cycle <= rsp_cycle + 1;
        // recurring long ready stretches, patterned and random stalls elsewhere
        if (rsp_cycle % 3000 < 600) rsp_if.ready <= 1'b1;
        else rsp_if.ready <= stall_pattern[rsp_cycle % 16] | ($urandom_range(0, 3) == 0);
    end

    // apb write: setup then access, pready is always high
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for every expected transaction, then let the block settle
    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_groups(int unsigned n);
        drain_results();
        apb_write(3'(REG_GROUPS_IN_USE * 4), 32'(n));
        grp_setting = n & 32'h7f;
    endtask

    // send one request; with keep_valid set, valid stays high across back-to-back transactions
    task automatic send_request(t_op op, logic [IDX_W-1:0] idx, bit keep_valid);
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.block_index <= idx;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (!keep_valid) req_if.valid <= 1'b0;
    endtask

    // runs one request through predictor and block, optional literal check
    task automatic issue(t_op op, logic [IDX_W-1:0] idx, bit keep_valid,
                         bit has_exp = 1'b0, t_result lit = '0);
        t_result p;
        p = allocate_predict(op, idx);
        if (has_exp && p !== lit) begin
            $display("%0t table row: expected %0d/%0d/%0d, actual predictor %0d/%0d/%0d",
                     $time, lit.blk, lit.status, lit.free_cnt, p.blk, p.status, p.free_cnt);
            mismatches++;
        end
        pending_results.push_back(has_exp ? lit : p);
        send_request(op, idx, keep_valid);
    endtask

    function automatic t_row mk(t_op op, int idx, bit h = 1'b0, int b = 0,
                                t_status s = ST_OK, int f = 0);
        t_row r;
        r.op = op;
        r.idx = IDX_W'(idx);
        r.has_exp = h;
        r.exp.blk = IDX_W'(b);
        r.exp.status = s;
        r.exp.free_cnt = CNT_W'(f);
        return r;
    endfunction

    t_row directed[$];

    // random request: mostly inside the configured capacity so state gets deep
    task automatic random_item(bit keep_valid);
        int unsigned eff;
        int unsigned sel;
        t_op         op;
        logic [IDX_W-1:0] idx;
        eff = (grp_setting > GROUPS) ? GROUPS : grp_setting;
        sel = $urandom_range(0, 99);
        if (sel < 45) op = OP_ALLOC;
        else if (sel < 65) op = OP_MARK;
        else if (sel < 95) op = OP_RELEASE;
        else op = OP_NONE;
        sel = $urandom_range(0, 9);
        if (sel < 6 && eff != 0) idx = IDX_W'($urandom_range(0, eff*GRP_BLOCKS - 1));
        else if (sel < 8) idx = IDX_W'($urandom_range(0, 1023));
        else idx = IDX_W'($urandom);
        issue(op, idx, keep_valid);
    endtask

    initial begin
        req_if.valid       = 1'b0;
        req_if.operation   = OP_NONE;
        req_if.block_index = '0;
        mismatches  = 0;
        used_blocks = 0;
        grp_setting = 64;
        foreach (blk_used[i]) blk_used[i] = 1'b0;
        foreach (grp_full[i]) grp_full[i] = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, extremes, every operation, same-state results
        directed.push_back(mk(OP_ALLOC,   0,     1, 0,     ST_OK,    16383));
        directed.push_back(mk(OP_ALLOC,   16383, 1, 1,     ST_OK,    16382));
        directed.push_back(mk(OP_MARK,    16383, 1, 16383, ST_OK,    16381));
        directed.push_back(mk(OP_MARK,    16383, 1, 16383, ST_SAME,  16381));
        directed.push_back(mk(OP_RELEASE, 5,     1, 5,     ST_SAME,  16381));
        directed.push_back(mk(OP_RELEASE, 0,     1, 0,     ST_OK,    16382));
        directed.push_back(mk(OP_ALLOC,   0,     1, 0,     ST_OK,    16381));
        directed.push_back(mk(OP_NONE,    12345, 1, 0,     ST_OK,    16381));
        directed.push_back(mk(OP_MARK,    2,     1, 2,     ST_OK,    16380));
        directed.push_back(mk(OP_ALLOC,   0,     1, 3,     ST_OK,    16379));
        directed.push_back(mk(OP_RELEASE, 16383, 1, 16383, ST_OK,    16380));
        directed.push_back(mk(OP_MARK,    8192));
        directed.push_back(mk(OP_RELEASE, 1));
        directed.push_back(mk(OP_ALLOC,   0));
        foreach (directed[i])
            issue(directed[i].op, directed[i].idx, i != directed.size() - 1,
                  directed[i].has_exp, directed[i].exp);

        // one group: fill it, hit full, range errors, release reopens it
        set_groups(1);
        for (int i = 0; i < 260; i++) issue(OP_ALLOC, 0, 1'b1);
        issue(OP_MARK, 256, 1'b1, 1'b1, '{IDX_W'(256), ST_RANGE, CNT_W'(0)});
        issue(OP_RELEASE, 16383, 1'b1);
        issue(OP_RELEASE, 100, 1'b1);
        issue(OP_MARK, 100, 1'b1);
        issue(OP_RELEASE, 255, 1'b1);
        issue(OP_ALLOC, 0, 1'b0);

        // zero groups: nothing allocatable, every index out of range
        set_groups(0);
        issue(OP_ALLOC, 0, 1'b1, 1'b1, '{IDX_W'(0), ST_NO_FREE, CNT_W'(0)});
        issue(OP_MARK, 0, 1'b1, 1'b1, '{IDX_W'(0), ST_RANGE, CNT_W'(0)});
        issue(OP_RELEASE, 0, 1'b0, 1'b1, '{IDX_W'(0), ST_RANGE, CNT_W'(0)});

        // above group count acts as all groups; top register bit set
        set_groups(127);
        issue(OP_MARK, 16383, 1'b1);
        issue(OP_ALLOC, 0, 1'b0);

        // random phases across several group settings, bursty sender
        for (int phase = 0; phase < 5; phase++) begin
            int unsigned n_items;
            int unsigned burst;
            case (phase)
                0: set_groups(2);
                1: set_groups(64);
                2: set_groups($urandom_range(1, 8));
                3: set_groups(1);
                default: set_groups($urandom_range(1, 127));
            endcase
            n_items = N_RANDOM / 5;
            while (n_items > 0) begin
                burst = $urandom_range(1, 12);
                if (burst > n_items) burst = n_items;
                for (int k = 0; k < burst; k++)
                    random_item(k != burst - 1);
                n_items -= burst;
                // a gap so valid drops before the next burst
                if ($urandom_range(0, 5) == 0) drain_results();
                else repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog: clear pass plus slowest run, many times over
    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/tlba_pkg.sv
hdl/tlba_if.sv
hdl/tlba_map_ram.sv
hdl/two_level_bitmap_block_allocator.sv
bench/tb_two_level_bitmap_block_allocator.sv
